// ----- rtl/tsxb_pkg.sv -----
// shared types and constants for the timestamped xor basis unit
// no dependencies; imported by the controller, datapath, top level and checker
`timescale 1ns / 1ps

package tsxb_pkg;

   // fixed request and response field widths
   localparam int WORD_W  = 20;
   localparam int STAMP_W = 16;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_QMIN   = 2'd2,
      CMD_QMAX   = 2'd3
   } cmd_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // request accepted this cycle
      logic step;      // process the current bit position
      logic rsp_load;  // move the reduced word into the response register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;      // current position is bit zero
      logic stop;      // insert lands in an empty row at this position
      logic is_query;  // held command is not an insert (a query while walking)
      logic rsp_free;  // response register can take a new result
   } dp_status_type;

endpackage

// ----- rtl/timestamped_xor_basis_unit.sv -----
// top level of the timestamped xor basis unit
// depends on tsxb_pkg, tsxb_ctrl and tsxb_datapath
`timescale 1ns / 1ps

// Keeps a GF(2) basis of BITS-bit words, one row per leading bit, each row
// tagged with a STAMP_BITS-bit stamp. A request carries a command: clear
// empties the basis in the cycle it is accepted; a stamped insert walks the
// bit positions from high to low, letting the newer word displace an older
// row; a min or max query reduces the given word over the rows whose stamp
// is at least the request's stamp and returns the reduced word and a zero
// flag. Only queries produce a response. Timing: the unit takes one request
// at a time and walks one bit position per cycle through the single read
// port of the row registers; a clear finishes in its acceptance cycle, an
// insert ends early when it fills an empty row, and a query loads its response
// into the output register once the walk has reached bit zero.
// The response sits in an output register, so a new request is taken while
// an earlier response still waits; a query only stalls at its end if that
// register is still full.

module timestamped_xor_basis_unit
   import tsxb_pkg::*;
#(
   parameter int BITS       = 20,
   parameter int STAMP_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic [WORD_W-1:0]  req_word,
   input  logic [STAMP_W-1:0] req_stamp,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [WORD_W-1:0]  rsp_reduced,
   output logic               rsp_is_zero
);

   ctrl_cmd_type  ctrl_cmd;   // sequencing from the state machine
   dp_status_type dp_status;  // walk position, early stop, response slot
   cmd_type       req_op;

   // every 2-bit code is a defined command
   assign req_op = cmd_type'(req_cmd);

   tsxb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_op),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   tsxb_datapath #(
      .BITS       (BITS),
      .STAMP_BITS (STAMP_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_cmd     (req_op),
      .req_word    (req_word),
      .req_stamp   (req_stamp),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_reduced (rsp_reduced),
      .rsp_is_zero (rsp_is_zero),
      .cmd         (ctrl_cmd),
      .status      (dp_status)
   );

endmodule

// ----- rtl/tsxb_ctrl.sv -----
// controller state machine for the timestamped xor basis unit
// depends on tsxb_pkg; drives the datapath through ctrl_cmd_type
`timescale 1ns / 1ps

module tsxb_ctrl
   import tsxb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  cmd_type       req_cmd,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.step     = 1'b0;
      cmd.rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_cmd != CMD_CLEAR) begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (status.stop) begin
               state_in = ST_IDLE;
            end else if (status.last) begin
               state_in = status.is_query ? ST_DONE : ST_IDLE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/tsxb_datapath.sv -----
// row store, carried word and response register of the xor basis unit
// depends on tsxb_pkg; sequenced by tsxb_ctrl
`timescale 1ns / 1ps

module tsxb_datapath
   import tsxb_pkg::*;
#(
   parameter int BITS       = 20,
   parameter int STAMP_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            req_cmd,
   input  logic [WORD_W-1:0]  req_word,
   input  logic [STAMP_W-1:0] req_stamp,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [WORD_W-1:0]  rsp_reduced,
   output logic               rsp_is_zero,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status
);

   localparam int POS_W = $clog2(BITS);
   localparam logic [POS_W-1:0] POS_TOP = POS_W'(BITS - 1);

   logic [BITS-1:0]       row_word_ff  [BITS];
   logic [STAMP_BITS-1:0] row_stamp_ff [BITS];
   logic [BITS-1:0]       row_used_ff, row_used_in;

   logic [BITS-1:0]       carry_word_ff, carry_word_in;
   logic [STAMP_BITS-1:0] carry_stamp_ff, carry_stamp_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   cmd_type               op_ff, op_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     rsp_word_ff;
   logic                  rsp_zero_ff;

   logic [BITS-1:0]       cur_word;
   logic [STAMP_BITS-1:0] cur_stamp;
   logic                  cur_used;
   logic                  bit_set;
   logic                  is_insert;
   logic                  row_write;
   logic                  swap;
   logic                  eligible;
   logic                  flip;

   assign cur_word  = row_word_ff[pos_ff];
   assign cur_stamp = row_stamp_ff[pos_ff];
   assign cur_used  = row_used_ff[pos_ff];
   assign bit_set   = carry_word_ff[pos_ff];
   assign is_insert = (op_ff == CMD_INSERT);

   // insert: older row gives way to the carried word; equal stamps keep the row
   assign swap      = cur_used && (cur_stamp < carry_stamp_ff);
   assign row_write = cmd.step && is_insert && bit_set && (!cur_used || swap);

   // query: only used rows at or above the threshold stamp take part
   assign eligible  = cur_used && (cur_stamp >= carry_stamp_ff);
   assign flip      = (op_ff == CMD_QMAX) ? !bit_set : bit_set;

   always_comb begin
      carry_word_in  = carry_word_ff;
      carry_stamp_in = carry_stamp_ff;
      pos_in         = pos_ff;
      op_in          = op_ff;
      row_used_in    = row_used_ff;
      if (cmd.load) begin
         carry_word_in  = BITS'(req_word);
         carry_stamp_in = STAMP_BITS'(req_stamp);
         pos_in         = POS_TOP;
         op_in          = req_cmd;
         if (req_cmd == CMD_CLEAR) begin
            row_used_in = '0;
         end
      end else if (cmd.step) begin
         pos_in = pos_ff - POS_W'(1);
         if (is_insert) begin
            // after a swap the carry is old row ^ new row, same as without one
            if (bit_set) begin
               carry_word_in = carry_word_ff ^ cur_word;
               if (swap) begin
                  carry_stamp_in = cur_stamp;
               end
            end
            if (row_write) begin
               row_used_in[pos_ff] = 1'b1;
            end
         end else if (eligible && flip) begin
            carry_word_in = carry_word_ff ^ cur_word;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_used_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_used_ff  <= row_used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_word_ff  <= carry_word_in;
      carry_stamp_ff <= carry_stamp_in;
      pos_ff         <= pos_in;
      op_ff          <= op_in;
      if (row_write) begin
         row_word_ff[pos_ff]  <= carry_word_ff;
         row_stamp_ff[pos_ff] <= carry_stamp_ff;
      end
      if (cmd.rsp_load) begin
         rsp_word_ff <= WORD_W'(carry_word_ff);
         rsp_zero_ff <= (carry_word_ff == '0);
      end
   end

   assign status.last     = (pos_ff == '0);
   assign status.stop     = is_insert && bit_set && !cur_used;
   assign status.is_query = !is_insert;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_reduced = rsp_word_ff;
   assign rsp_is_zero = rsp_zero_ff;

endmodule

// ----- rtl/tsxb_checker.sv -----
// port-level checks for the timestamped xor basis unit, bound to the top level
// depends on tsxb_pkg and timestamped_xor_basis_unit
`timescale 1ns / 1ps

module tsxb_checker
   import tsxb_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_cmd,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [WORD_W-1:0]  rsp_reduced,
   input logic               rsp_is_zero
);

   // a pending response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reduced)
         && $stable(rsp_is_zero))
      else $error("response changed while stalled");

   // an accepted insert or query drops req_ready while its walk runs
   a_busy_after_walk: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd != CMD_CLEAR) |=> !req_ready)
      else $error("request taken while a walk is running");

   // a clear completes in its acceptance cycle
   a_clear_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_CLEAR) |=> req_ready)
      else $error("clear held the unit busy");

   // a set zero flag comes with an all-zero reduced word
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_zero |-> (rsp_reduced == '0))
      else $error("zero flag set on a non-zero word");

endmodule

bind timestamped_xor_basis_unit tsxb_checker u_tsxb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_cmd     (req_cmd),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_reduced (rsp_reduced),
   .rsp_is_zero (rsp_is_zero)
);
